>>> sv/tspt_pkg.sv
// Shared types and constants for the touch scroll packet tracker.
// Used by the channel interfaces, the serial divider and the top level.
`default_nettype none

package tspt_pkg;

  // Packet and result widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CapW    = 6;
  localparam int unsigned PosW    = 12;
  localparam int unsigned AmountW = 13;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned SpanW    = 13;

  // Signed position change (wrap can push it to about +/-8190)
  localparam int unsigned DiffW = 15;
  // Magnitude of a position change, fed to the divider
  localparam int unsigned MagW  = DiffW - 1;
  localparam int unsigned DivW  = PosW;
  localparam int unsigned StepW = $clog2(MagW);

  // Largest reported movement
  localparam logic [MagW-1:0] AmountMax = MagW'(4095);

  // Packet field positions
  localparam int unsigned PosHiW   = 4;
  localparam int unsigned GuardBit = 4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegWheelMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTouchLevel    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPalmLevel     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartDistance = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMoveDivisor   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCircleSpan    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxStep       = 3'd6;

  // Register reset values
  localparam logic [CapW-1:0]  TouchLevelRst    = 6'd8;
  localparam logic [CapW-1:0]  PalmLevelRst     = 6'd40;
  localparam logic [PosW-1:0]  StartDistanceRst = 12'd30;
  localparam logic [PosW-1:0]  MoveDivisorRst   = 12'd8;
  localparam logic [SpanW-1:0] CircleSpanRst    = 13'd4096;
  localparam logic [PosW-1:0]  MaxStepRst       = 12'd2048;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LAST,
    ST_START,
    ST_DIVIDE,
    ST_REPORT
  } state_t;

endpackage

`default_nettype wire

>>> sv/tspt_if.sv
// Valid/ready channel interfaces: packet words in, report words out.
// Depends on tspt_pkg for field widths.
`default_nettype none

interface tspt_in_if;
  logic                          valid;
  logic                          ready;
  logic [tspt_pkg::ByteW-1:0]    byte_zero;
  logic [tspt_pkg::ByteW-1:0]    byte_one;
  logic [tspt_pkg::ByteW-1:0]    byte_two;
  logic [tspt_pkg::ByteW-1:0]    byte_four;

  modport source (output valid, byte_zero, byte_one, byte_two, byte_four, input ready);
  modport sink   (input valid, byte_zero, byte_one, byte_two, byte_four, output ready);
endinterface

interface tspt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 report_valid;
  logic signed [tspt_pkg::AmountW-1:0]  scroll_amount;

  modport source (output valid, report_valid, scroll_amount, input ready);
  modport sink   (input valid, report_valid, scroll_amount, output ready);
endinterface

`default_nettype wire

>>> sv/tspt_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tspt_pkg for operand widths and the step count.
`default_nettype none

module tspt_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tspt_pkg::MagW-1:0]   dividend,
  input  wire logic [tspt_pkg::DivW-1:0]   divisor,
  output logic                             done,
  output logic [tspt_pkg::MagW-1:0]        quotient
);

  logic                          busy;
  logic [tspt_pkg::StepW-1:0]    count;
  logic [tspt_pkg::DivW-1:0]     rem;
  logic [tspt_pkg::DivW-1:0]     div;
  logic [tspt_pkg::DivW:0]       trial;
  logic                          fits;
  logic [tspt_pkg::DivW-1:0]     rem_next;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    trial    = {rem, quotient[tspt_pkg::MagW-1]};
    fits     = trial >= {1'b0, div};
    rem_next = fits ? tspt_pkg::DivW'(trial - {1'b0, div})
                    : trial[tspt_pkg::DivW-1:0];
  end

  // Control: count the steps and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == tspt_pkg::StepW'(tspt_pkg::MagW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      div      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[tspt_pkg::MagW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> sv/touch_scroll_packet_tracker_unit.sv
// Touch scroll packet tracker: top level with sequencer and register file.
// Depends on tspt_pkg, tspt_if (channels) and tspt_div (serial divider).
//
// Takes one scroll packet word and returns exactly one report word for it.
// Capacitance at or above touch_level starts or continues a touch; once the
// touch has moved past start_distance from its start, movement since the last
// report is negated, divided by move_divisor (toward zero, zero acts as one)
// and saturated to +/-4095. Wheel mode wraps differences by circle_span when
// they exceed max_step. A packet is accepted in the idle state and decoded; a
// continuing touch then uses the shared position-difference unit in the last
// and start states and, once it has moved far enough, goes through the divide
// step for its 14 quotient bits before the report word is offered. A packet
// that starts or ends a touch, or comes with no touch, goes from decode
// straight to the report state; a touch that has not yet moved far enough
// skips the divide step. The block then waits until the report word is taken
// and only then is ready for the next packet. Configuration may be written
// while no packet is in flight.
`default_nettype none

module touch_scroll_packet_tracker_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  tspt_in_if.sink                             packet,
  tspt_out_if.source                          report,
  input  wire logic                           cfg_we,
  input  wire logic [tspt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [tspt_pkg::CfgDataW-1:0]  cfg_data
);

  // Configuration registers
  logic                          wheel_mode;
  logic [tspt_pkg::CapW-1:0]     touch_level;
  logic [tspt_pkg::CapW-1:0]     palm_level;
  logic [tspt_pkg::PosW-1:0]     start_distance;
  logic [tspt_pkg::PosW-1:0]     move_divisor;
  logic [tspt_pkg::SpanW-1:0]    circle_span;
  logic [tspt_pkg::PosW-1:0]     max_step;

  // Touch state
  logic                          touch_active;
  logic [tspt_pkg::PosW-1:0]     last_position;
  logic [tspt_pkg::PosW-1:0]     start_position;
  logic                          ignore_touch;
  logic                          moved_enough;
  logic                          guard_previous;

  // Captured packet
  logic [tspt_pkg::CapW-1:0]     cap;
  logic [tspt_pkg::PosW-1:0]     pos;
  logic                          guard;

  // Sequencer and datapath
  tspt_pkg::state_t              state;
  tspt_pkg::state_t              state_next;
  logic signed [tspt_pkg::DiffW-1:0] mv;
  logic signed [tspt_pkg::DiffW-1:0] change;
  logic [tspt_pkg::PosW-1:0]     base_position;
  logic [tspt_pkg::MagW-1:0]     change_mag;
  logic [tspt_pkg::MagW-1:0]     mv_mag;
  logic                          moved_next;
  logic                          ignore_next;
  logic                          div_start;
  logic                          div_done;
  logic [tspt_pkg::MagW-1:0]     div_quo;
  logic [tspt_pkg::DivW-1:0]     div_use;
  logic [tspt_pkg::MagW-1:0]     sat_mag;
  logic signed [tspt_pkg::AmountW-1:0] q_amount;
  logic                          rep_valid;
  logic signed [tspt_pkg::AmountW-1:0] rep_amount;
  logic                          finger_on;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_mode     <= 1'b0;
      touch_level    <= tspt_pkg::TouchLevelRst;
      palm_level     <= tspt_pkg::PalmLevelRst;
      start_distance <= tspt_pkg::StartDistanceRst;
      move_divisor   <= tspt_pkg::MoveDivisorRst;
      circle_span    <= tspt_pkg::CircleSpanRst;
      max_step       <= tspt_pkg::MaxStepRst;
    end else if (cfg_we) begin
      case (cfg_index)
        tspt_pkg::RegWheelMode:     wheel_mode     <= cfg_data[0];
        tspt_pkg::RegTouchLevel:    touch_level    <= cfg_data[tspt_pkg::CapW-1:0];
        tspt_pkg::RegPalmLevel:     palm_level     <= cfg_data[tspt_pkg::CapW-1:0];
        tspt_pkg::RegStartDistance: start_distance <= cfg_data[tspt_pkg::PosW-1:0];
        tspt_pkg::RegMoveDivisor:   move_divisor   <= cfg_data[tspt_pkg::PosW-1:0];
        tspt_pkg::RegCircleSpan:    circle_span    <= cfg_data[tspt_pkg::SpanW-1:0];
        tspt_pkg::RegMaxStep:       max_step       <= cfg_data[tspt_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // Shared position-difference unit: one subtract, then an optional wrap
  always_comb begin
    base_position = (state == tspt_pkg::ST_LAST) ? last_position : start_position;
    change = tspt_pkg::DiffW'({3'b000, pos}) - tspt_pkg::DiffW'({3'b000, base_position});
    if (wheel_mode) begin
      if (change > $signed({3'b000, max_step})) begin
        change = change - $signed({2'b00, circle_span});
      end else if (change < -$signed({3'b000, max_step})) begin
        change = change + $signed({2'b00, circle_span});
      end
    end
    change_mag = change[tspt_pkg::DiffW-1] ? tspt_pkg::MagW'(-change)
                                           : tspt_pkg::MagW'(change);
    mv_mag     = mv[tspt_pkg::DiffW-1] ? tspt_pkg::MagW'(-mv) : tspt_pkg::MagW'(mv);
  end

  // Flag updates for a continuing touch, the touch test and the effective divisor
  always_comb begin
    moved_next  = moved_enough || (change_mag > {2'b00, start_distance});
    ignore_next = ignore_touch || guard || (cap > palm_level);
    finger_on   = cap >= touch_level;
    div_use     = (move_divisor == '0) ? tspt_pkg::DivW'(1) : move_divisor;
  end

  // Saturate the quotient and give it the opposite sign of the movement
  always_comb begin
    sat_mag  = (div_quo > tspt_pkg::AmountMax) ? tspt_pkg::AmountMax : div_quo;
    q_amount = mv[tspt_pkg::DiffW-1] ? tspt_pkg::AmountW'(sat_mag)
                                     : -tspt_pkg::AmountW'(sat_mag);
  end

  tspt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mv_mag),
    .divisor  (div_use),
    .done     (div_done),
    .quotient (div_quo)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tspt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next   = state;
    packet.ready = 1'b0;
    report.valid = 1'b0;
    div_start    = 1'b0;
    case (state)
      tspt_pkg::ST_IDLE: begin
        packet.ready = 1'b1;
        if (packet.valid) begin
          state_next = tspt_pkg::ST_DECODE;
        end
      end
      tspt_pkg::ST_DECODE: begin
        state_next = (finger_on && touch_active) ? tspt_pkg::ST_LAST
                                                 : tspt_pkg::ST_REPORT;
      end
      tspt_pkg::ST_LAST: begin
        state_next = tspt_pkg::ST_START;
      end
      tspt_pkg::ST_START: begin
        if (moved_next) begin
          div_start  = 1'b1;
          state_next = tspt_pkg::ST_DIVIDE;
        end else begin
          state_next = tspt_pkg::ST_REPORT;
        end
      end
      tspt_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = tspt_pkg::ST_REPORT;
        end
      end
      tspt_pkg::ST_REPORT: begin
        report.valid = 1'b1;
        if (report.ready) begin
          state_next = tspt_pkg::ST_IDLE;
        end
      end
      default: state_next = tspt_pkg::ST_IDLE;
    endcase
  end

  assign report.report_valid  = rep_valid;
  assign report.scroll_amount = rep_amount;

  // Capture the packet word
  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      cap   <= packet.byte_zero[tspt_pkg::CapW-1:0];
      pos   <= {packet.byte_one[tspt_pkg::PosHiW-1:0], packet.byte_two};
      guard <= packet.byte_four[tspt_pkg::GuardBit];
    end
  end

  // Hold the movement since the last report
  always_ff @(posedge clk) begin
    if (state == tspt_pkg::ST_LAST) begin
      mv <= change;
    end
  end

  // Advance touch state and build the report word
  always_ff @(posedge clk) begin
    if (rst) begin
      touch_active   <= 1'b0;
      last_position  <= '0;
      start_position <= '0;
      ignore_touch   <= 1'b0;
      moved_enough   <= 1'b0;
      guard_previous <= 1'b0;
      rep_valid      <= 1'b0;
      rep_amount     <= '0;
    end else begin
      case (state)
        tspt_pkg::ST_DECODE: begin
          guard_previous <= guard;
          rep_valid      <= 1'b0;
          rep_amount     <= '0;
          if (finger_on) begin
            if (!touch_active) begin
              touch_active   <= 1'b1;
              last_position  <= pos;
              start_position <= pos;
              ignore_touch   <= guard_previous;
            end
          end else if (touch_active) begin
            if (guard) begin
              ignore_touch <= 1'b1;
            end
            touch_active <= 1'b0;
            moved_enough <= 1'b0;
          end
        end
        tspt_pkg::ST_START: begin
          moved_enough <= moved_next;
          ignore_touch <= ignore_next;
        end
        tspt_pkg::ST_DIVIDE: begin
          if (div_done && (sat_mag != '0) && !ignore_touch) begin
            rep_valid     <= 1'b1;
            rep_amount    <= q_amount;
            last_position <= pos;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Input and output sides are never open at once
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(packet.ready && report.valid))
    else $error("packet ready while a report word is offered");

  // A word without a report carries zero movement
  a_zero_amount: assert property (@(posedge clk) disable iff (rst)
    (report.valid && !report.report_valid) |-> (report.scroll_amount == '0))
    else $error("nonzero scroll amount without a report");

  // The divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == tspt_pkg::ST_DIVIDE))
    else $error("divider finished outside the divide step");

  // An accepted packet closes the input until its report is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (packet.valid && packet.ready) |=> !packet.ready)
    else $error("packet accepted back to back");
`endif

endmodule

`default_nettype wire
